FILE: rtl/core/pcd_pkg.sv
// Shared types, constants and the hex digit decode for the percent decoder.
`default_nettype none

package pcd_pkg;

	localparam logic [7:0] PCT_CHAR  = 8'h25;
	localparam logic [7:0] CASE_MASK = 8'hDF;

	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QFILL_W = $clog2(QDEPTH + 1);

	// Bytes produced by one input beat, oldest in bytes[0].
	typedef struct packed {
		logic [1:0]      cnt;
		logic            last;
		logic [2:0][7:0] bytes;
	} group_t;

	// Returns {is_hex, nibble}.
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [7:0] u;
		begin
			u = c & CASE_MASK;
			if (c >= 8'h30 && c <= 8'h39) begin
				hex_nib = {1'b1, c[3:0]};
			end else if (u >= 8'h41 && u <= 8'h46) begin
				hex_nib = {1'b1, u[3:0] + 4'd9};
			end else begin
				hex_nib = 5'b0;
			end
		end
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcd_front.sv
// Front end: accepts raw beats, tracks pending escape state, and forms output groups.
`default_nettype none

module pcd_front import pcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       q_full,
	output logic            push,
	output group_t          push_grp
);

	typedef enum logic [1:0] {
		P_NONE,
		P_PCT,
		P_DIGIT
	} pend_t;

	pend_t      st_q, nst;
	logic [7:0] dig_q, ndig;
	logic [4:0] cur_hex, dig_hex;
	logic [1:0] n;
	logic       fresh;
	logic       accept;
	group_t     grp;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign cur_hex  = hex_nib(in_byte);
	assign dig_hex  = hex_nib(dig_q);

	always_comb begin
		grp   = '0;
		n     = 2'd0;
		nst   = st_q;
		ndig  = dig_q;
		fresh = 1'b0;
		case (st_q)
			P_NONE: begin
				fresh = 1'b1;
			end
			P_PCT: begin
				if (cur_hex[4]) begin
					nst  = P_DIGIT;
					ndig = in_byte;
				end else begin
					grp.bytes[n] = PCT_CHAR;
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			P_DIGIT: begin
				if (cur_hex[4]) begin
					grp.bytes[n] = {dig_hex[3:0], cur_hex[3:0]};
					n = n + 2'd1;
					nst = P_NONE;
				end else begin
					grp.bytes[n] = PCT_CHAR;
					n = n + 2'd1;
					grp.bytes[n] = dig_q;
					n = n + 2'd1;
					fresh = 1'b1;
				end
			end
			default: begin
				nst = P_NONE;
			end
		endcase

		// A character outside any escape is either held as a new '%' or passed on.
		if (fresh) begin
			if (in_byte == PCT_CHAR) begin
				nst = P_PCT;
			end else begin
				grp.bytes[n] = in_byte;
				n = n + 2'd1;
				nst = P_NONE;
			end
		end

		// At the end of a string, whatever is still held goes out literally.
		if (in_last) begin
			case (nst)
				P_PCT: begin
					grp.bytes[n] = PCT_CHAR;
					n = n + 2'd1;
				end
				P_DIGIT: begin
					grp.bytes[n] = PCT_CHAR;
					n = n + 2'd1;
					grp.bytes[n] = ndig;
					n = n + 2'd1;
				end
				default: begin
				end
			endcase
			nst = P_NONE;
		end

		grp.cnt  = n;
		grp.last = in_last;
	end

	assign push     = accept && (n != 2'd0);
	assign push_grp = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= P_NONE;
			dig_q <= 8'h00;
		end else if (accept) begin
			st_q  <= nst;
			dig_q <= ndig;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pcd_queue.sv
// Small group queue that decouples the front end from the output serializer.
`default_nettype none

module pcd_queue import pcd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire group_t push_grp,
	input  wire logic   pop,
	output group_t      head,
	output logic        empty,
	output logic        full
);

	group_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QFILL_W-1:0]  fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == QFILL_W'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + QFILL_W'(1);
				2'b01:   fill_q <= fill_q - QFILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/pcd_back.sv
// Back end: serializes queued groups into single output beats through an output register.
`default_nettype none

module pcd_back import pcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire group_t     head,
	input  wire logic       empty,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic [1:0] idx_q;
	logic       load;
	logic       at_end;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	assign load   = !empty && (!out_valid_q || out_ready);
	assign at_end = (idx_q == head.cnt - 2'd1);
	assign pop    = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= head.bytes[idx_q];
			out_last_q <= head.last && at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/percent_decoder.sv
// Top level of the streaming URI percent decoder.
`default_nettype none

// Decodes a stream of URI characters, one beat per character, with in_last on the
// final character of each string. A '%' and two hex digits of either case become
// one byte; a broken escape is passed on literally and decoding resumes at the
// character that broke it; held characters are flushed literally at end of string,
// and out_last marks the final decoded byte. The front end takes one beat per
// cycle as long as the four-entry group queue has room. Each beat yields zero to
// three output bytes, and the output register sends one byte per cycle while
// out_ready is high, so a stream without broken escapes runs at one beat per
// cycle; a broken escape adds one or two output bytes that the queue absorbs.
// Each accepted beat's bytes pass through the group queue and the output register.
module percent_decoder import pcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic   push, pop, empty, full;
	group_t push_grp, head;

	pcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.q_full   (full),
		.push     (push),
		.push_grp (push_grp)
	);

	pcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	pcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire

FILE: rtl/core/pcd_checker.sv
// Port-level checks for the percent decoder and their binding to the top level.
`default_nettype none

module pcd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	// A stalled output beat must hold until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("output beat changed while stalled");

	// The queue only fills from an accepted beat, so ready drops only after one.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready fell without an accepted beat");

	// A full queue implies the output register is loaded.
	a_full_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled while no output is offered");

endmodule

bind percent_decoder pcd_checker u_pcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.out_last  (out_last)
);

`default_nettype wire
